/* sv/ascp_pkg.sv */
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared types, character codes and helpers of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

	localparam int FRAME_CHAR_LIMIT_DEF = 80;

	// result kinds
	localparam logic [2:0] KIND_FRAME    = 3'd0;
	localparam logic [2:0] KIND_ACK      = 3'd1;
	localparam logic [2:0] KIND_SEND_ERR = 3'd2;
	localparam logic [2:0] KIND_OVERFLOW = 3'd3;
	localparam logic [2:0] KIND_BAD_LEN  = 3'd4;

	// character codes
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_BEL  = 8'h07;
	localparam logic [7:0] CH_ACK  = 8'h7a; // 'z'
	localparam logic [7:0] CH_STD  = 8'h74; // 't'
	localparam logic [7:0] CH_EXT  = 8'h54; // 'T'
	localparam logic [7:0] CH_RTR  = 8'h72; // 'r'
	localparam logic [7:0] CH_XRTR = 8'h52; // 'R'
	localparam logic [7:0] CH_ZERO = 8'h30; // '0'
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;

	localparam logic [3:0] MAX_DLC    = 4'd8;
	localparam logic [3:0] BAD_LENGTH = 4'd15;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] can_id;
		logic        extended;
		logic        remote;
		logic [3:0]  data_length;
		logic [63:0] payload;
		logic [15:0] time_stamp;
	} out_item_t;

	// {valid, digit}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				return {1'b1, d[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
				return {1'b1, d[3:0]};
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
				return {1'b1, d[3:0]};
			end
			return 5'b0_0000;
		end
	endfunction

endpackage

/* sv/ascp_chan_if.sv */
// ----------------------------------------------------------------------------
// ascp_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ascp_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/ascp_parser.sv */
// ----------------------------------------------------------------------------
// ascp_parser
// Parse state registers and the per-character update; gives at most one
// result for each character taken.
// ----------------------------------------------------------------------------
module ascp_parser
	import ascp_pkg::*;
#(
	parameter int FRAME_CHAR_LIMIT = FRAME_CHAR_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] c,
	output logic       res_valid,
	output out_item_t  res
);

	localparam int CNT_W = $clog2(FRAME_CHAR_LIMIT);

	logic             in_frame_q, n_in_frame;
	logic [1:0]       frame_type_q, n_frame_type; // bit0 extended, bit1 remote
	logic [CNT_W-1:0] count_q, n_count;
	logic [31:0]      id_q, n_id;
	logic [3:0]       lc_q, n_lc;
	logic [63:0]      pay_q, n_pay;
	logic [15:0]      stamp_q, n_stamp;
	logic             stopped_q, n_stopped;

	logic [4:0]       hv;
	logic [CNT_W-1:0] dlc_pos, rel, lc2, trel;
	logic [CNT_W:0]   pos_inc;
	logic             ovf, is_lead, do_clear, do_open;
	logic             fld_act, fld_start, stop_eff;
	logic             sel_id, sel_pay, sel_stamp;
	logic [2:0]       byte_idx;

	always_comb begin
		hv       = hex_value(c);
		dlc_pos  = frame_type_q[0] ? CNT_W'(9) : CNT_W'(4);
		rel      = count_q - dlc_pos - CNT_W'(1);
		lc2      = CNT_W'({lc_q, 1'b0});
		trel     = frame_type_q[1] ? rel : rel - lc2;
		byte_idx = rel[3:1];
		pos_inc  = {1'b0, count_q} + (CNT_W+1)'(1);
		ovf      = pos_inc >= (CNT_W+1)'(FRAME_CHAR_LIMIT);
		is_lead  = (c == CH_STD) || (c == CH_EXT) || (c == CH_RTR) || (c == CH_XRTR);

		n_in_frame   = in_frame_q;
		n_frame_type = frame_type_q;
		n_count      = count_q;
		n_id         = id_q;
		n_lc         = lc_q;
		n_pay        = pay_q;
		n_stamp      = stamp_q;
		n_stopped    = stopped_q;
		res_valid    = 1'b0;
		res          = '0;
		do_clear     = 1'b0;
		do_open      = 1'b0;
		fld_act      = 1'b0;
		fld_start    = 1'b0;
		sel_id       = 1'b0;
		sel_pay      = 1'b0;
		sel_stamp    = 1'b0;
		stop_eff     = 1'b0;

		if (en) begin
			if (!in_frame_q) begin
				if (is_lead) begin
					do_clear = 1'b1;
					do_open  = 1'b1;
				end else if (c == CH_ACK) begin
					res_valid = 1'b1;
					res.kind  = KIND_ACK;
				end else if (c == CH_BEL) begin
					res_valid = 1'b1;
					res.kind  = KIND_SEND_ERR;
				end
			end else if (ovf) begin
				do_clear  = 1'b1;
				res_valid = 1'b1;
				res.kind  = KIND_OVERFLOW;
			end else begin
				n_count = pos_inc[CNT_W-1:0];
				if (c == CH_CR) begin
					do_clear  = 1'b1;
					res_valid = 1'b1;
					if (lc_q > MAX_DLC) begin
						res.kind = KIND_BAD_LEN;
					end else begin
						res.kind        = KIND_FRAME;
						res.can_id      = id_q;
						res.extended    = frame_type_q[0];
						res.remote      = frame_type_q[1];
						res.data_length = lc_q;
						res.payload     = frame_type_q[1] ? 64'd0 : pay_q;
						res.time_stamp  = stamp_q;
					end
				end else if (count_q < dlc_pos) begin
					fld_act   = 1'b1;
					fld_start = count_q == CNT_W'(1);
					sel_id    = 1'b1;
				end else if (count_q == dlc_pos) begin
					if (c >= CH_ZERO && c <= CH_ZERO + 8'(MAX_DLC)) begin
						n_lc = 4'(c - CH_ZERO);
					end else begin
						n_lc = BAD_LENGTH;
					end
				end else if (lc_q <= MAX_DLC) begin
					if (!frame_type_q[1] && rel < lc2) begin
						fld_act   = 1'b1;
						fld_start = !rel[0];
						sel_pay   = 1'b1;
					end else if (trel < CNT_W'(4)) begin
						fld_act   = 1'b1;
						fld_start = trel == CNT_W'(0);
						sel_stamp = 1'b1;
					end
				end

				// a hex field takes digits until its first non-hex character
				if (fld_act) begin
					stop_eff  = stopped_q && !fld_start;
					n_stopped = stop_eff || !hv[4];
					if (!stop_eff && hv[4]) begin
						if (sel_id)
							n_id = {id_q[27:0], hv[3:0]};
						if (sel_pay)
							n_pay[byte_idx*8 +: 8] = {pay_q[byte_idx*8 +: 4], hv[3:0]};
						if (sel_stamp)
							n_stamp = {stamp_q[11:0], hv[3:0]};
					end
				end
			end
		end

		if (do_clear) begin
			n_in_frame   = 1'b0;
			n_frame_type = 2'b00;
			n_count      = '0;
			n_id         = '0;
			n_lc         = '0;
			n_pay        = '0;
			n_stamp      = '0;
			n_stopped    = 1'b0;
		end
		if (do_open) begin
			n_in_frame   = 1'b1;
			n_frame_type = {(c == CH_RTR) || (c == CH_XRTR), (c == CH_EXT) || (c == CH_XRTR)};
			n_count      = CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			frame_type_q <= 2'b00;
			count_q      <= '0;
			id_q         <= '0;
			lc_q         <= '0;
			pay_q        <= '0;
			stamp_q      <= '0;
			stopped_q    <= 1'b0;
		end else begin
			in_frame_q   <= n_in_frame;
			frame_type_q <= n_frame_type;
			count_q      <= n_count;
			id_q         <= n_id;
			lc_q         <= n_lc;
			pay_q        <= n_pay;
			stamp_q      <= n_stamp;
			stopped_q    <= n_stopped;
		end
	end

endmodule

/* sv/ascii_can_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Receive-side parser of an ASCII CAN adapter character stream.
// ----------------------------------------------------------------------------
// rx: one received character per transfer (rx.data.rx_byte).
// tx: one result per transfer: a parsed frame, a send acknowledge ('z'),
//     a send error (BEL), an overflow or a bad-length report. Most characters
//     give no result; a frame appears on the CR that closes it.
// Each character is captured in an input register, then the parse state and
// the result register are updated from it once the result register is free
// or being drained; the result is then shown on tx from the result register.
// Throughput is one character per cycle while tx does not stall; rx.ready
// stays high while the result register is empty or being drained. When tx
// stalls with a result waiting, one more character is held in the input
// register and rx.ready drops until the result is taken; nothing is lost or
// repeated. Reset clears the input register, the result register and the
// parse state (idle, outside a frame). There is no clearing pass; the block
// takes characters as soon as reset is released.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser
	import ascp_pkg::*;
#(
	parameter int FRAME_CHAR_LIMIT = FRAME_CHAR_LIMIT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ascp_chan_if.sink     rx,
	ascp_chan_if.source   tx
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	out_item_t  res;
	logic       tx_valid_q;
	out_item_t  tx_data_q;

	assign advance  = valid_s1 && (!tx_valid_q || tx.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid)
			byte_s1 <= rx.data.rx_byte;
	end

	ascp_parser #(
		.FRAME_CHAR_LIMIT (FRAME_CHAR_LIMIT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.c         (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			tx_valid_q <= 1'b1;
		end else if (tx.ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			tx_data_q <= res;
	end

	assign tx.valid = tx_valid_q;
	assign tx.data  = tx_data_q;

	// non-frame results carry nothing but their kind
	a_nonframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_data_q.kind != KIND_FRAME |->
		tx_data_q.can_id == 32'd0 && tx_data_q.payload == 64'd0 &&
		tx_data_q.time_stamp == 16'd0 && tx_data_q.data_length == 4'd0 &&
		!tx_data_q.extended && !tx_data_q.remote)
		else $error("non-frame result with nonzero fields");

	a_frame_dlc: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_data_q.kind == KIND_FRAME |-> tx_data_q.data_length <= MAX_DLC)
		else $error("frame result with DLC above 8");

	a_remote_nopay: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_data_q.remote |-> tx_data_q.payload == 64'd0)
		else $error("remote frame with payload");

	a_in_captured: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |=> valid_s1)
		else $error("transferred character not held in input register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && !tx.ready |-> !advance)
		else $error("parser advanced while result stalled");

endmodule
